/* rtl/core/iphc_pkg.sv */
// ============================================================================
// IPv4 receive header checker package
// Shared types and constants for the header checker: the per-frame summary
// handed from the byte parser to the verdict stage, verdict codes, and
// configuration register indexes.
// ============================================================================
package iphc_pkg;

    // Link header length in bytes and the saturation value of the byte counter.
    localparam int unsigned LINK_HDR_BYTES = 14;
    localparam int unsigned COUNT_W        = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    // Shortest frame that holds a link header and a minimal IPv4 header.
    localparam logic [COUNT_W-1:0] MIN_FRAME_LEN = 17'd34;

    // Header field constants.
    localparam logic [3:0]  IP_VERSION_4 = 4'h4;
    localparam logic [3:0]  IHL_MIN      = 4'd5;
    localparam logic [15:0] CSUM_GOOD    = 16'hFFFF;
    localparam logic [31:0] ADDR_BCAST   = 32'hFFFF_FFFF;

    // Protocol numbers that get their own class.
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_ADDR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_EN  = 2'd1;

    // Verdict codes.
    typedef enum logic [3:0] {
        VERDICT_ICMP        = 4'd0,
        VERDICT_UDP         = 4'd1,
        VERDICT_TCP         = 4'd2,
        VERDICT_OTHER       = 4'd3,
        VERDICT_SHORT       = 4'd4,
        VERDICT_VERSION     = 4'd5,
        VERDICT_IHL         = 4'd6,
        VERDICT_HDR_BEYOND  = 4'd7,
        VERDICT_TOT_BEYOND  = 4'd8,
        VERDICT_CSUM        = 4'd9,
        VERDICT_FRAG        = 4'd10,
        VERDICT_NOT_OURS    = 4'd11,
        VERDICT_TOTAL_SHORT = 4'd12
    } verdict_t;

    // Everything the verdict stage needs to know about one finished frame.
    typedef struct packed {
        logic [COUNT_W-1:0] frame_len;
        logic [7:0]         version_ihl;
        logic [20:0]        sum_acc;
        logic [15:0]        total_length;
        logic [15:0]        frag_word;
        logic [7:0]         proto;
        logic [31:0]        source;
        logic [31:0]        dest;
    } frame_sum_t;

endpackage

/* rtl/core/ipv4_receive_header_checker.sv */
// ============================================================================
// IPv4 receive header checker
// Parses Ethernet frames byte by byte and gives one IPv4 verdict per frame.
// ============================================================================
// The block takes one frame byte per clock while in_stall is low, with no gaps
// required, and gives one result per frame. Each byte is parsed as it is taken;
// at the last byte the frame's summary goes into a queue of QUEUE_DEPTH
// entries, and a verdict stage judges one summary per cycle, while the output
// register is free or being drained, into a registered output. Input stall
// rises only when that queue is full, which takes sustained output stall.
// There is no clearing pass after reset; configuration writes take effect on
// the next frame judged and are accepted every cycle.
module ipv4_receive_header_checker
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       frame_byte,
    input  logic                             last,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [3:0]                       verdict,
    output logic [7:0]                       protocol,
    output logic [31:0]                      src_addr,
    output logic [6:0]                       payload_offset,
    output logic [15:0]                      payload_length,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [iphc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);
    import iphc_pkg::*;

    logic [31:0] local_addr_reg;
    logic        filter_en_reg;
    logic        byte_take;
    logic        q_push, q_pop, q_full, q_empty;
    frame_sum_t  push_data, pop_data;

    // Configuration registers, written on each transfer of the config port.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg <= '0;
            filter_en_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOCAL_ADDR: local_addr_reg <= cfg_data;
                CFG_FILTER_EN:  filter_en_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Input transfer.
    assign in_stall  = q_full;
    assign byte_take = in_valid && !in_stall;

    iphc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_take  (byte_take),
        .frame_byte (frame_byte),
        .last       (last),
        .sum_push   (q_push),
        .sum_data   (push_data)
    );

    iphc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    iphc_back u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .local_addr         (local_addr_reg),
        .addr_filter_enable (filter_en_reg),
        .q_empty            (q_empty),
        .q_data             (pop_data),
        .q_pop              (q_pop),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .verdict            (verdict),
        .protocol           (protocol),
        .src_addr           (src_addr),
        .payload_offset     (payload_offset),
        .payload_length     (payload_length)
    );

endmodule

/* rtl/core/iphc_front.sv */
// ============================================================================
// IPv4 header checker byte parser
// Counts frame bytes, captures the IPv4 header fields, accumulates the header
// checksum, and on the last byte of a frame pushes a frame summary.
// ============================================================================
module iphc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_take,
    input  logic [7:0]           frame_byte,
    input  logic                 last,
    output logic                 sum_push,
    output iphc_pkg::frame_sum_t sum_data
);
    import iphc_pkg::*;

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]         version_ihl_reg, version_ihl_next;
    logic [20:0]        sum_acc_reg, sum_acc_next;
    logic [7:0]         high_byte_reg, high_byte_next;
    logic [15:0]        total_length_reg, total_length_next;
    logic [15:0]        frag_word_reg, frag_word_next;
    logic [7:0]         proto_reg, proto_next;
    logic [31:0]        source_reg, source_next;
    logic [31:0]        dest_reg, dest_next;

    logic               in_hdr;
    logic [COUNT_W-1:0] off;
    logic [3:0]         ihl_now;
    logic [COUNT_W-1:0] hlen;
    logic [COUNT_W-1:0] frame_len;

    // Position of the current byte inside the IPv4 header.
    assign in_hdr    = (byte_count_reg >= COUNT_W'(LINK_HDR_BYTES));
    assign off       = byte_count_reg - COUNT_W'(LINK_HDR_BYTES);
    assign frame_len = (byte_count_reg != COUNT_MAX) ? byte_count_reg + 1'b1 : COUNT_MAX;

    // Header length in bytes, taking the IHL from the current byte when it carries it.
    assign ihl_now = (in_hdr && (off == COUNT_W'(0))) ? frame_byte[3:0]
                                                      : version_ihl_reg[3:0];
    assign hlen    = {{(COUNT_W-6){1'b0}}, ihl_now, 2'b00};

    // Field capture and checksum update for the current byte.
    always_comb
    begin
        version_ihl_next  = version_ihl_reg;
        total_length_next = total_length_reg;
        frag_word_next    = frag_word_reg;
        proto_next        = proto_reg;
        source_next       = source_reg;
        dest_next         = dest_reg;
        high_byte_next    = high_byte_reg;
        sum_acc_next      = sum_acc_reg;

        if (in_hdr)
        begin
            if (off == COUNT_W'(0))
            begin
                version_ihl_next = frame_byte;
            end
            if (off == COUNT_W'(2))
            begin
                total_length_next[15:8] = frame_byte;
            end
            if (off == COUNT_W'(3))
            begin
                total_length_next[7:0] = frame_byte;
            end
            if (off == COUNT_W'(6))
            begin
                frag_word_next[15:8] = frame_byte;
            end
            if (off == COUNT_W'(7))
            begin
                frag_word_next[7:0] = frame_byte;
            end
            if (off == COUNT_W'(9))
            begin
                proto_next = frame_byte;
            end
            for (int i = 0; i < 4; i++)
            begin
                if (off == COUNT_W'(12 + i))
                begin
                    source_next[8*i +: 8] = source_reg[8*i +: 8] | frame_byte;
                end
                if (off == COUNT_W'(16 + i))
                begin
                    dest_next[8*i +: 8] = dest_reg[8*i +: 8] | frame_byte;
                end
            end
        end

        // Only bytes inside the header length, using the IHL just captured.
        if (in_hdr && (off < hlen))
        begin
            if (!off[0])
            begin
                high_byte_next = frame_byte;
            end
            else
            begin
                sum_acc_next = sum_acc_reg + {5'd0, high_byte_reg, frame_byte};
            end
        end
    end

    // Summary of the finished frame, including the effect of its last byte.
    assign sum_push              = byte_take && last;
    assign sum_data.frame_len    = frame_len;
    assign sum_data.version_ihl  = version_ihl_next;
    assign sum_data.sum_acc      = sum_acc_next;
    assign sum_data.total_length = total_length_next;
    assign sum_data.frag_word    = frag_word_next;
    assign sum_data.proto        = proto_next;
    assign sum_data.source       = source_next;
    assign sum_data.dest         = dest_next;

    // Per-frame state: advance on every byte, clear after the last one.
    assign byte_count_next = last ? '0 : frame_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            version_ihl_reg  <= '0;
            sum_acc_reg      <= '0;
            high_byte_reg    <= '0;
            total_length_reg <= '0;
            frag_word_reg    <= '0;
            proto_reg        <= '0;
            source_reg       <= '0;
            dest_reg         <= '0;
        end
        else if (byte_take)
        begin
            byte_count_reg <= byte_count_next;
            if (last)
            begin
                version_ihl_reg  <= '0;
                sum_acc_reg      <= '0;
                high_byte_reg    <= '0;
                total_length_reg <= '0;
                frag_word_reg    <= '0;
                proto_reg        <= '0;
                source_reg       <= '0;
                dest_reg         <= '0;
            end
            else
            begin
                version_ihl_reg  <= version_ihl_next;
                sum_acc_reg      <= sum_acc_next;
                high_byte_reg    <= high_byte_next;
                total_length_reg <= total_length_next;
                frag_word_reg    <= frag_word_next;
                proto_reg        <= proto_next;
                source_reg       <= source_next;
                dest_reg         <= dest_next;
            end
        end
    end

endmodule

/* rtl/core/iphc_queue.sv */
// ============================================================================
// IPv4 header checker summary queue
// Short first-in first-out queue of frame summaries between the byte parser
// and the verdict stage.
// ============================================================================
module iphc_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  iphc_pkg::frame_sum_t push_data,
    output logic                 full,
    input  logic                 pop,
    output iphc_pkg::frame_sum_t pop_data,
    output logic                 empty
);
    import iphc_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    frame_sum_t       entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage for the queued summaries.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    // A transfer into a full queue or out of an empty one would lose or invent a frame.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("summary pushed into a full queue");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("summary popped from an empty queue");

endmodule

/* rtl/core/iphc_back.sv */
// ============================================================================
// IPv4 header checker verdict stage
// Judges one queued frame summary per cycle while the output register is free or
// being drained, and holds the result there until the downstream side takes it.
// ============================================================================
module iphc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          local_addr,
    input  logic                 addr_filter_enable,
    input  logic                 q_empty,
    input  iphc_pkg::frame_sum_t q_data,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [3:0]           verdict,
    output logic [7:0]           protocol,
    output logic [31:0]          src_addr,
    output logic [6:0]           payload_offset,
    output logic [15:0]          payload_length
);
    import iphc_pkg::*;

    logic        out_valid_reg, out_valid_next;
    verdict_t    verdict_reg, verdict_next;
    logic [7:0]  protocol_reg;
    logic [31:0] src_addr_reg;
    logic [6:0]  payload_offset_reg, payload_offset_next;
    logic [15:0] payload_length_reg, payload_length_next;

    logic [5:0]         hlen;
    logic [COUNT_W-1:0] hdr_end;
    logic [COUNT_W-1:0] tot_end;
    logic [16:0]        fold1;
    logic [15:0]        fold2;

    // Header length, end offsets and the folded one's complement sum.
    assign hlen    = {q_data.version_ihl[3:0], 2'b00};
    assign hdr_end = COUNT_W'(LINK_HDR_BYTES) + {{(COUNT_W-6){1'b0}}, hlen};
    assign tot_end = COUNT_W'(LINK_HDR_BYTES) + {{(COUNT_W-16){1'b0}}, q_data.total_length};
    assign fold1   = {1'b0, q_data.sum_acc[15:0]} + {12'd0, q_data.sum_acc[20:16]};
    assign fold2   = fold1[15:0] + {15'd0, fold1[16]};

    // Checks in priority order; a frame that passes is classed by protocol.
    always_comb
    begin
        payload_offset_next = '0;
        payload_length_next = '0;
        if (q_data.frame_len < MIN_FRAME_LEN)
        begin
            verdict_next = VERDICT_SHORT;
        end
        else if (q_data.version_ihl[7:4] != IP_VERSION_4)
        begin
            verdict_next = VERDICT_VERSION;
        end
        else if (q_data.version_ihl[3:0] < IHL_MIN)
        begin
            verdict_next = VERDICT_IHL;
        end
        else if (hdr_end > q_data.frame_len)
        begin
            verdict_next = VERDICT_HDR_BEYOND;
        end
        else if (tot_end > q_data.frame_len)
        begin
            verdict_next = VERDICT_TOT_BEYOND;
        end
        else if (fold2 != CSUM_GOOD)
        begin
            verdict_next = VERDICT_CSUM;
        end
        else if (q_data.frag_word[13:0] != '0)
        begin
            verdict_next = VERDICT_FRAG;
        end
        else if (addr_filter_enable && (q_data.dest != local_addr)
                 && (q_data.dest != ADDR_BCAST))
        begin
            verdict_next = VERDICT_NOT_OURS;
        end
        else if (q_data.total_length < {10'd0, hlen})
        begin
            verdict_next = VERDICT_TOTAL_SHORT;
        end
        else
        begin
            payload_offset_next = 7'(LINK_HDR_BYTES) + {1'b0, hlen};
            payload_length_next = q_data.total_length - {10'd0, hlen};
            if (q_data.proto == PROTO_ICMP)
            begin
                verdict_next = VERDICT_ICMP;
            end
            else if (q_data.proto == PROTO_UDP)
            begin
                verdict_next = VERDICT_UDP;
            end
            else if (q_data.proto == PROTO_TCP)
            begin
                verdict_next = VERDICT_TCP;
            end
            else
            begin
                verdict_next = VERDICT_OTHER;
            end
        end
    end

    // Take a new summary whenever the output register is empty or being drained.
    assign q_pop          = !q_empty && (!out_valid_reg || !out_stall);
    assign out_valid_next = q_pop || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded only on a new summary.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            verdict_reg        <= verdict_next;
            protocol_reg       <= q_data.proto;
            src_addr_reg       <= q_data.source;
            payload_offset_reg <= payload_offset_next;
            payload_length_reg <= payload_length_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign verdict        = verdict_reg;
    assign protocol       = protocol_reg;
    assign src_addr       = src_addr_reg;
    assign payload_offset = payload_offset_reg;
    assign payload_length = payload_length_reg;

    // A dropped frame reports no payload, and a popped summary always reaches the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (verdict_reg >= VERDICT_SHORT))
        |-> (payload_offset_reg == '0) && (payload_length_reg == '0))
        else $error("dropped frame reports a payload");
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> out_valid_reg)
        else $error("popped summary did not reach the output register");

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the IPv4 receive header checker
// Streams Ethernet frames into the checker one byte per transfer. A local
// predictor follows every accepted byte and queues the verdict that each
// frame's last byte should give. A checker process compares each result
// transfer against the oldest queued verdict, field by field.
// ----------------------------------------------------------------------------
module tb;

    import iphc_pkg::*;

    // Run limits, in nanoseconds and clock cycles.
    localparam int RUN_LIMIT_NS = 2_000_000;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 16;

    // Register indexes that the block does not decode.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 2'd3;

    // Bytes of the random part, per configuration phase.
    localparam int unsigned PHASE_BYTES = 170;

    // Ways in which a random frame is damaged.
    typedef enum int {
        FAULT_NONE,
        FAULT_VERSION,
        FAULT_IHL,
        FAULT_CSUM,
        FAULT_FRAG,
        FAULT_TOTAL,
        FAULT_TRUNCATE,
        FAULT_NOISE
    } frame_fault_t;

    // Header fields from which one test frame is built.
    typedef struct {
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [15:0] total;
        logic [15:0] frag;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        bit          bad_csum;
        int unsigned tail;
    } ip_hdr_spec_t;

    // One verdict as the block should report it.
    typedef struct packed {
        verdict_t    verdict;
        logic [7:0]  protocol;
        logic [31:0] src;
        logic [6:0]  poff;
        logic [15:0] plen;
    } ip_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [7:0]             frame_byte = 8'h00;
    logic                   last = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [3:0]             verdict;
    logic [7:0]             protocol;
    logic [31:0]            src_addr;
    logic [6:0]             payload_offset;
    logic [15:0]            payload_length;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_LOCAL_ADDR;
    logic [31:0]            cfg_data = 32'h0;

    // Traffic shaping shared by the sender and the receiver.
    logic idle_on = 1'b1;
    logic hold_results = 1'b0;
    int   stall_run = 0;

    // Predicted register contents.
    logic [31:0] own_addr = 32'h0;
    logic        own_filter = 1'b1;

    // Predicted per-frame parser state.
    logic [16:0] rx_count = '0;
    logic [7:0]  rx_vihl = '0;
    logic [20:0] rx_sum = '0;
    logic [7:0]  rx_hi = '0;
    logic [15:0] rx_total = '0;
    logic [15:0] rx_frag = '0;
    logic [7:0]  rx_proto = '0;
    logic [31:0] rx_src = '0;
    logic [31:0] rx_dst = '0;

    ip_result_t  expected_results[$];
    ip_result_t  due_result;
    logic [7:0]  tx_frame[$];

    int unsigned bytes_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned delivered_count = 0;
    int unsigned dropped_count = 0;
    int unsigned reg_writes = 0;
    int unsigned results_checked = 0;
    int unsigned error_count = 0;

    ipv4_receive_header_checker u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .frame_byte     (frame_byte),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .verdict        (verdict),
        .protocol       (protocol),
        .src_addr       (src_addr),
        .payload_offset (payload_offset),
        .payload_length (payload_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("ERROR at %0t, result %0d, %s: got 0x%0h, want 0x%0h",
                 $time, results_checked, what, got, want);
    endtask

    // Clear the predicted parser state, as the block does after each frame.
    function automatic void clear_rx_state();
        rx_count = '0;
        rx_vihl  = '0;
        rx_sum   = '0;
        rx_hi    = '0;
        rx_total = '0;
        rx_frag  = '0;
        rx_proto = '0;
        rx_src   = '0;
        rx_dst   = '0;
    endfunction

    // Work out the verdict of a finished frame of flen bytes.
    function automatic ip_result_t judge_frame(input int unsigned flen);
        ip_result_t  r;
        int unsigned hlen;
        int unsigned folded;
        r.verdict  = VERDICT_OTHER;
        r.protocol = rx_proto;
        r.src      = rx_src;
        r.poff     = '0;
        r.plen     = '0;
        hlen   = 4 * rx_vihl[3:0];
        folded = rx_sum;
        while ((folded >> 16) != 0)
            folded = (folded & 32'hFFFF) + (folded >> 16);
        if (flen < MIN_FRAME_LEN)
            r.verdict = VERDICT_SHORT;
        else if (rx_vihl[7:4] != IP_VERSION_4)
            r.verdict = VERDICT_VERSION;
        else if (rx_vihl[3:0] < IHL_MIN)
            r.verdict = VERDICT_IHL;
        else if (LINK_HDR_BYTES + hlen > flen)
            r.verdict = VERDICT_HDR_BEYOND;
        else if (LINK_HDR_BYTES + rx_total > flen)
            r.verdict = VERDICT_TOT_BEYOND;
        else if (folded != CSUM_GOOD)
            r.verdict = VERDICT_CSUM;
        else if (rx_frag[12:0] != 13'h0 || rx_frag[13])
            r.verdict = VERDICT_FRAG;
        else if (own_filter && rx_dst != own_addr && rx_dst != ADDR_BCAST)
            r.verdict = VERDICT_NOT_OURS;
        else if (rx_total < hlen)
            r.verdict = VERDICT_TOTAL_SHORT;
        else
        begin
            r.poff = 7'(LINK_HDR_BYTES + hlen);
            r.plen = 16'(rx_total - hlen);
            case (rx_proto)
                PROTO_ICMP: r.verdict = VERDICT_ICMP;
                PROTO_UDP:  r.verdict = VERDICT_UDP;
                PROTO_TCP:  r.verdict = VERDICT_TCP;
                default:    r.verdict = VERDICT_OTHER;
            endcase
        end
        return r;
    endfunction

    // Follow one accepted byte; on the last byte queue the frame's verdict.
    function automatic void track_byte(input logic [7:0] b, input logic lst);
        int unsigned pos;
        int unsigned off;
        int unsigned hlen;
        int unsigned flen;
        ip_result_t  r;
        pos = rx_count;
        if (pos >= LINK_HDR_BYTES)
        begin
            off = pos - LINK_HDR_BYTES;
            if (off == 0)
                rx_vihl = b;
            else if (off == 2)
                rx_total[15:8] = b;
            else if (off == 3)
                rx_total[7:0] = b;
            else if (off == 6)
                rx_frag[15:8] = b;
            else if (off == 7)
                rx_frag[7:0] = b;
            else if (off == 9)
                rx_proto = b;
            else if (off >= 12 && off < 16)
                rx_src[8 * (off - 12) +: 8] = b;
            else if (off >= 16 && off < 20)
                rx_dst[8 * (off - 16) +: 8] = b;
            // Only bytes inside the header as given by IHL enter the sum.
            hlen = 4 * rx_vihl[3:0];
            if (off < hlen)
            begin
                if (off % 2 == 0)
                    rx_hi = b;
                else
                    rx_sum = rx_sum + {5'h0, rx_hi, b};
            end
        end
        // The byte counter saturates instead of wrapping.
        flen = (pos < COUNT_MAX) ? pos + 1 : COUNT_MAX;
        rx_count = 17'(flen);
        if (lst)
        begin
            r = judge_frame(flen);
            expected_results.push_back(r);
            if (r.verdict <= VERDICT_OTHER)
                delivered_count++;
            else
                dropped_count++;
            clear_rx_state();
        end
    endfunction

    // Result checker: every result transfer is matched to the oldest verdict.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with none expected", 32'(verdict), 32'h0);
            else
            begin
                due_result = expected_results.pop_front();
                if (verdict !== due_result.verdict)
                    report_mismatch("verdict", 32'(verdict), 32'(due_result.verdict));
                if (protocol !== due_result.protocol)
                    report_mismatch("protocol", 32'(protocol), 32'(due_result.protocol));
                if (src_addr !== due_result.src)
                    report_mismatch("src_addr", src_addr, due_result.src);
                if (payload_offset !== due_result.poff)
                    report_mismatch("payload_offset", 32'(payload_offset),
                                    32'(due_result.poff));
                if (payload_length !== due_result.plen)
                    report_mismatch("payload_length", 32'(payload_length),
                                    32'(due_result.plen));
                results_checked++;
            end
        end
    end

    // Receiver: random single-cycle stalls, occasional long bursts, or a hold.
    always @(negedge clk)
    begin
        if (hold_results)
            out_stall <= 1'b1;
        else if (stall_run != 0)
        begin
            out_stall <= 1'b1;
            stall_run <= stall_run - 1;
        end
        else if (idle_on && $urandom_range(999) < 6)
        begin
            out_stall <= 1'b1;
            stall_run <= int'($urandom_range(24, 8));
        end
        else
            out_stall <= idle_on && ($urandom_range(99) < 14);
    end

    // Transfer one frame byte, with random gaps before it.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while (idle_on && $urandom_range(99) < 23)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        frame_byte = b;
        last       = lst;
        do
            @(posedge clk);
        while (in_stall);
        track_byte(b, lst);
        bytes_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Transfer the frame held in tx_frame, marking its final byte.
    task automatic send_frame();
        int unsigned n;
        for (n = 0; n < tx_frame.size(); n++)
            send_byte(tx_frame[n], n == tx_frame.size() - 1);
        frames_sent++;
    endtask

    // Hold the sender until every queued verdict has been delivered.
    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Register write, issued only once the block has gone idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_LOCAL_ADDR)
            own_addr = data;
        else if (idx == CFG_FILTER_EN)
            own_filter = data[0];
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // The filter enable is written with random upper bits.
    task automatic write_filter(input logic en);
        logic [31:0] d;
        d    = $urandom;
        d[0] = en;
        write_reg(CFG_FILTER_EN, d);
    endtask

    // A well-formed header for the local address with plen payload bytes.
    function automatic ip_hdr_spec_t good_spec(input int unsigned ihl,
                                               input int unsigned plen);
        ip_hdr_spec_t s;
        s.ver      = IP_VERSION_4;
        s.ihl      = 4'(ihl);
        s.total    = 16'(4 * ihl + plen);
        s.frag     = 16'h0000;
        s.proto    = PROTO_UDP;
        s.src      = $urandom;
        s.dst      = own_addr;
        s.bad_csum = 1'b0;
        s.tail     = plen;
        return s;
    endfunction

    // Build a frame: random link header, IPv4 header with its checksum, tail.
    function automatic void build_frame(input ip_hdr_spec_t s);
        logic [7:0]  hdr[60];
        int unsigned hbytes;
        int unsigned n;
        logic [31:0] acc;
        logic [15:0] csum;
        tx_frame.delete();
        repeat (LINK_HDR_BYTES) tx_frame.push_back(8'($urandom));
        hbytes = (s.ihl < IHL_MIN) ? 20 : 4 * s.ihl;
        for (n = 0; n < 60; n++)
            hdr[n] = 8'($urandom);
        hdr[0]  = {s.ver, s.ihl};
        hdr[2]  = s.total[15:8];
        hdr[3]  = s.total[7:0];
        hdr[6]  = s.frag[15:8];
        hdr[7]  = s.frag[7:0];
        hdr[9]  = s.proto;
        hdr[10] = 8'h00;
        hdr[11] = 8'h00;
        for (n = 0; n < 4; n++)
        begin
            hdr[12 + n] = s.src[8 * n +: 8];
            hdr[16 + n] = s.dst[8 * n +: 8];
        end
        // Ones' complement sum over the span that IHL gives.
        acc = 32'h0;
        for (n = 0; n + 1 < 4 * s.ihl; n += 2)
            acc = acc + {16'h0, hdr[n], hdr[n + 1]};
        while (acc[31:16] != 16'h0)
            acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        csum = ~acc[15:0];
        if (s.bad_csum)
            csum = csum ^ 16'($urandom_range(16'hFFFF, 1));
        hdr[10] = csum[15:8];
        hdr[11] = csum[7:0];
        for (n = 0; n < hbytes; n++)
            tx_frame.push_back(hdr[n]);
        repeat (s.tail) tx_frame.push_back(8'($urandom));
    endfunction

    function automatic void noise_frame(input int unsigned len);
        tx_frame.delete();
        repeat (len) tx_frame.push_back(8'($urandom));
    endfunction

    function automatic void truncate_to(input int unsigned len);
        while (tx_frame.size() > len)
            void'(tx_frame.pop_back());
    endfunction

    // Mostly well-formed packets with random content; the rest damaged or noise.
    function automatic void build_random_frame();
        ip_hdr_spec_t s;
        frame_fault_t fault;
        int unsigned  ihl;
        int unsigned  plen;
        ihl  = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : IHL_MIN;
        plen = $urandom_range(40);
        s = good_spec(ihl, plen);
        if ($urandom_range(3) == 0)
            s.tail = plen + $urandom_range(8, 1);
        case ($urandom_range(3))
            0, 1:    s.dst = own_addr;
            2:       s.dst = ADDR_BCAST;
            default: s.dst = $urandom;
        endcase
        case ($urandom_range(4))
            0:       s.proto = PROTO_ICMP;
            1:       s.proto = PROTO_UDP;
            2:       s.proto = PROTO_TCP;
            default: s.proto = 8'($urandom);
        endcase
        // Only the reserved and don't-fragment bits, which do not drop.
        if ($urandom_range(2) == 0)
            s.frag = 16'($urandom) & 16'hC000;
        fault = ($urandom_range(99) < 70) ? FAULT_NONE : frame_fault_t'($urandom_range(7, 1));
        case (fault)
            FAULT_VERSION: s.ver = 4'($urandom);
            FAULT_IHL:     s.ihl = 4'($urandom);
            FAULT_CSUM:    s.bad_csum = 1'b1;
            FAULT_FRAG:    s.frag = 16'($urandom);
            FAULT_TOTAL:   s.total = 16'($urandom_range(4 * ihl + plen + 16));
            default:       ;
        endcase
        if (fault == FAULT_NOISE)
            noise_frame($urandom_range(80, 1));
        else
        begin
            build_frame(s);
            if (fault == FAULT_TRUNCATE)
                truncate_to($urandom_range(tx_frame.size() - 1, 1));
        end
    endfunction

    // Reset values: local address 0 with the filter on.
    task automatic test_reset_values();
        ip_hdr_spec_t s;
        s = good_spec(5, 12);
        build_frame(s);
        send_frame();
        s = good_spec(5, 4);
        s.dst = 32'h0102_0304;
        build_frame(s);
        send_frame();
        s = good_spec(5, 0);
        s.dst = ADDR_BCAST;
        build_frame(s);
        send_frame();
    endtask

    // The ICMP, TCP and other protocol classes, address extremes and the longest header.
    task automatic test_protocol_classes();
        ip_hdr_spec_t s;
        s = good_spec(5, 8);
        s.proto = PROTO_ICMP;
        s.src   = 32'h0000_0000;
        build_frame(s);
        send_frame();
        s = good_spec(6, 3);
        s.proto = PROTO_TCP;
        s.src   = 32'hFFFF_FFFF;
        build_frame(s);
        send_frame();
        s = good_spec(5, 1);
        s.proto = 8'h00;
        build_frame(s);
        send_frame();
        s = good_spec(5, 2);
        s.proto = 8'hFF;
        build_frame(s);
        send_frame();
        // Longest header with an empty payload, plus link padding.
        s = good_spec(15, 0);
        s.tail = 6;
        build_frame(s);
        send_frame();
    endtask

    // Each drop reason in the block's order of checks.
    task automatic test_drop_reasons();
        ip_hdr_spec_t s;
        // Frames too short to hold both headers.
        noise_frame(1);
        send_frame();
        s = good_spec(5, 0);
        build_frame(s);
        truncate_to(MIN_FRAME_LEN - 1);
        send_frame();
        // A frame of zeros fails on its version before its sum.
        tx_frame.delete();
        repeat (MIN_FRAME_LEN) tx_frame.push_back(8'h00);
        send_frame();
        s = good_spec(5, 4);
        s.ver = 4'hF;
        build_frame(s);
        send_frame();
        // IHL below the minimum.
        s = good_spec(5, 4);
        s.ihl = 4'h0;
        build_frame(s);
        send_frame();
        s = good_spec(5, 4);
        s.ihl = 4'h4;
        build_frame(s);
        send_frame();
        // Header that runs past the end of the frame.
        s = good_spec(15, 0);
        build_frame(s);
        truncate_to(LINK_HDR_BYTES + 50);
        send_frame();
        // Total length one byte beyond the frame.
        s = good_spec(5, 10);
        s.total = s.total + 16'd1;
        build_frame(s);
        send_frame();
        s = good_spec(5, 6);
        s.bad_csum = 1'b1;
        build_frame(s);
        send_frame();
        // More-fragments bit, then the largest fragment offset.
        s = good_spec(5, 6);
        s.frag = 16'h2000;
        build_frame(s);
        send_frame();
        s = good_spec(5, 6);
        s.frag = 16'h1FFF;
        build_frame(s);
        send_frame();
        s = good_spec(5, 6);
        s.frag = 16'hC000;
        build_frame(s);
        send_frame();
        s = good_spec(5, 6);
        s.dst = own_addr ^ 32'h8000_0001;
        build_frame(s);
        send_frame();
        // Total length below the header length.
        s = good_spec(5, 6);
        s.total = 16'd19;
        build_frame(s);
        send_frame();
        s = good_spec(5, 0);
        s.total = 16'd0;
        build_frame(s);
        send_frame();
    endtask

    // Register settings, including the undecoded indexes.
    task automatic test_config_settings();
        ip_hdr_spec_t s;
        write_filter(1'b0);
        s = good_spec(5, 5);
        s.dst = 32'h0A00_0001;
        build_frame(s);
        send_frame();
        write_reg(CFG_LOCAL_ADDR, $urandom);
        write_filter(1'b1);
        s = good_spec(5, 7);
        build_frame(s);
        send_frame();
        s = good_spec(5, 7);
        s.dst = ~own_addr;
        build_frame(s);
        send_frame();
        write_reg(CFG_LOCAL_ADDR, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED_LO, $urandom);
        write_reg(CFG_UNUSED_HI, $urandom);
        s = good_spec(5, 3);
        s.dst = 32'h0000_0000;
        build_frame(s);
        send_frame();
        s = good_spec(5, 3);
        build_frame(s);
        send_frame();
        write_reg(CFG_LOCAL_ADDR, 32'h0000_0000);
    endtask

    // Held results fill the verdict queue until the input stalls.
    task automatic test_backpressure();
        int unsigned n;
        bit          burst_done;
        burst_done = 1'b0;
        wait_drained();
        hold_results = 1'b1;
        fork
            begin
                for (n = 0; n < 20; n++)
                begin
                    noise_frame(1);
                    send_frame();
                end
                burst_done = 1'b1;
            end
            begin
                do
                    @(negedge clk);
                while (!in_stall && !burst_done);
                hold_results = 1'b0;
            end
        join
        hold_results = 1'b0;
    endtask

    // Random traffic in phases, each under its own register setting.
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned start;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_LOCAL_ADDR, $urandom);
                    write_filter(1'b1);
                end
                1:
                begin
                    write_reg(CFG_LOCAL_ADDR, 32'hFFFF_FFFF);
                    write_filter(1'b0);
                    idle_on = 1'b0;
                end
                2:
                begin
                    write_reg(CFG_LOCAL_ADDR, 32'h0000_0000);
                    write_filter(1'b1);
                    idle_on = 1'b1;
                end
                default:
                begin
                    write_reg(CFG_LOCAL_ADDR, $urandom);
                    write_filter(1'($urandom_range(1)));
                end
            endcase
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
            begin
                build_random_frame();
                send_frame();
            end
        end
        idle_on = 1'b1;
    endtask

    // Test sequence.
    initial
    begin
        clear_rx_state();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_values();
        test_protocol_classes();
        test_drop_reasons();
        test_config_settings();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Sent %0d frames in %0d bytes: %0d delivered, %0d dropped.",
                 frames_sent, bytes_sent, delivered_count, dropped_count);
        $display("Checked %0d results across %0d register writes; %0d errors.",
                 results_checked, reg_writes, error_count);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
